@@ hw/rtl/eqtd_pkg.sv @@
// Shared types and constants for the event queue / timer dispatcher.
// No dependencies.
package eqtd_pkg;

  typedef enum logic [1:0] {
    ACT_POST      = 2'd0,
    ACT_SUBSCRIBE = 2'd1,
    ACT_ADD_TIMER = 2'd2,
    ACT_PROCESS   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_FULL    = 3'd2,
    ST_DUP     = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  // One accepted command as it travels from the front end to the back end.
  typedef struct packed {
    action_t     action;
    logic [7:0]  event_id;
    logic [31:0] value;
    logic [7:0]  subscriber_id;
    logic [31:0] period_ms;
    logic [31:0] offset_ms;
    logic        oneshot;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_event_id;
    logic [31:0] out_value;
    logic [7:0]  subscriber_mask;
    logic        last;
  } result_t;

endpackage

@@ hw/rtl/event_queue_timer_dispatcher_top.sv @@
// Top level of the event queue / timer dispatcher.
// Depends on eqtd_pkg, eqtd_front and eqtd_back.
//
// Commands arrive on the s_axis channel and results leave on m_axis. Post,
// subscribe and add-timer each give one result once the item is accepted,
// and the back end takes the next item after that result has been taken.
// Process walks the timer table, visiting each used slot in S_SCAN and
// S_TIMER, then drains the event queue with one result per event (an empty
// queue gives one ST_EMPTY result). The back end sequencer works on one
// command at a time while a two-entry command queue in front keeps accepting
// while it has room. event_count is to be written on the cfg channel by the
// user only while the block is idle; the block itself does not enforce it.
module event_queue_timer_dispatcher_top import eqtd_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int SUBSCRIBERS = 8,
  parameter int TIMERS      = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: action[1:0], event_id[9:2], value[41:10], subscriber_id[49:42],
  // period_ms[81:50], offset_ms[113:82], oneshot[114], now_ms[146:115]
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status[2:0], out_event_id[10:3], out_value[42:11], mask[50:43]
  output logic [55:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data
);

  logic [7:0] event_count;
  cmd_t       in_cmd;
  cmd_t       q_cmd;
  logic       q_valid;
  logic       q_ready;
  result_t    res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) event_count <= 8'd255;
    else if (cfg_valid) event_count <= cfg_data;
  end

  assign in_cmd.action        = action_t'(s_axis_tdata[1:0]);
  assign in_cmd.event_id      = s_axis_tdata[9:2];
  assign in_cmd.value         = s_axis_tdata[41:10];
  assign in_cmd.subscriber_id = s_axis_tdata[49:42];
  assign in_cmd.period_ms     = s_axis_tdata[81:50];
  assign in_cmd.offset_ms     = s_axis_tdata[113:82];
  assign in_cmd.oneshot       = s_axis_tdata[114];
  assign in_cmd.now_ms        = s_axis_tdata[146:115];

  eqtd_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd,
    .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
  );

  eqtd_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .SUBSCRIBERS(SUBSCRIBERS), .TIMERS(TIMERS)
  ) u_back (
    .clk, .rst, .event_count,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
  );

  assign m_axis_tdata = {5'd0, res.subscriber_mask, res.out_value,
                         res.out_event_id, res.status};
  assign m_axis_tlast = res.last;

endmodule

@@ hw/rtl/eqtd_front.sv @@
// Front end: accepts command items and holds them in a short queue.
// Depends on eqtd_pkg.
module eqtd_front import eqtd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  cmd_t       slot [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd   = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ hw/rtl/eqtd_back.sv @@
// Back end: sequencer that carries out commands against the queue,
// subscriber and timer stores. Depends on eqtd_pkg.
module eqtd_back import eqtd_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int SUBSCRIBERS = 8,
  parameter int TIMERS      = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] event_count,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output logic       res_valid,
  input  logic       res_ready,
  output result_t    res
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SW = (SUBSCRIBERS > 1) ? $clog2(SUBSCRIBERS) : 1;
  localparam int TW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int SCW = $clog2(SUBSCRIBERS + 1);
  localparam int TCW = $clog2(TIMERS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_TIMER, S_DRAIN, S_DRAIN_WAIT, S_OUT
  } state_t;

  state_t state;
  cmd_t   cur;

  // Event queue memory
  logic [7:0]    q_event [QUEUE_DEPTH];
  logic [31:0]   q_value [QUEUE_DEPTH];
  logic [QW-1:0] q_head;
  logic [QW-1:0] q_tail;
  logic [QW-1:0] q_tail_inc;
  logic [7:0]    rd_event;
  logic [31:0]   rd_value;

  // Subscriber table
  logic [7:0]     s_event  [SUBSCRIBERS];
  logic [7:0]     s_handle [SUBSCRIBERS];
  logic [SCW-1:0] s_used;

  // Timer table
  logic [7:0]     t_event  [TIMERS];
  logic [31:0]    t_period [TIMERS];
  logic [31:0]    t_last   [TIMERS];
  logic           t_active [TIMERS];
  logic           t_once   [TIMERS];
  logic [TCW-1:0] t_used;
  logic [TW-1:0]  t_idx;

  // Timer evaluation registers
  logic [31:0] t_elapsed;
  logic [32:0] t_two_per;
  logic [31:0] t_per_r;
  logic        t_due;

  logic       sub_dup;
  logic       tmr_dup;
  logic [7:0] mask_calc;
  status_t    post_st;

  assign q_tail_inc = (q_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : q_tail + 1'b1;

  always_comb begin
    if (cmd.event_id == 8'd0 || cmd.event_id >= event_count) post_st = ST_INVALID;
    else if (q_tail_inc == q_head) post_st = ST_FULL;
    else post_st = ST_OK;
  end

  always_comb begin
    sub_dup = 1'b0;
    for (int i = 0; i < SUBSCRIBERS; i++) begin
      if (SCW'(i) < s_used && s_event[i] == cur.event_id &&
          s_handle[i] == cur.subscriber_id) sub_dup = 1'b1;
    end
    tmr_dup = 1'b0;
    for (int i = 0; i < TIMERS; i++) begin
      if (TCW'(i) < t_used && t_active[i] && t_event[i] == cur.event_id &&
          t_period[i] == cur.period_ms && t_once[i] == cur.oneshot) tmr_dup = 1'b1;
    end
    mask_calc = '0;
    for (int i = 0; i < SUBSCRIBERS; i++) begin
      if (SCW'(i) < s_used && (s_event[i] == rd_event || s_event[i] == 8'd0))
        mask_calc[i] = 1'b1;
    end
  end

  assign cmd_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    rd_event <= q_event[q_head];
    rd_value <= q_value[q_head];
    if (rst) begin
      state     <= S_IDLE;
      q_head    <= '0;
      q_tail    <= '0;
      s_used    <= '0;
      t_used    <= '0;
      res_valid <= 1'b0;
      t_idx     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            t_idx <= '0;
            state <= (cmd.action == ACT_PROCESS) ? S_SCAN : S_OUT;
            res   <= '{(cmd.action == ACT_POST) ? post_st : ST_OK,
                       8'd0, 32'd0, 8'd0, 1'b1};
            if (cmd.action == ACT_POST && post_st == ST_OK) begin
              q_event[q_tail] <= cmd.event_id;
              q_value[q_tail] <= cmd.value;
              q_tail <= q_tail_inc;
            end
          end
        end
        S_OUT: begin
          // Subscribe and add-timer are resolved here against the tables
          if (!res_valid) begin
            if (cur.action == ACT_SUBSCRIBE) begin
              if (cur.subscriber_id == 8'd0) res.status <= ST_INVALID;
              else if (s_used >= SCW'(SUBSCRIBERS)) res.status <= ST_FULL;
              else if (sub_dup) res.status <= ST_DUP;
              else begin
                s_event[s_used[SW-1:0]]  <= cur.event_id;
                s_handle[s_used[SW-1:0]] <= cur.subscriber_id;
                s_used <= s_used + 1'b1;
              end
            end else if (cur.action == ACT_ADD_TIMER) begin
              if (t_used >= TCW'(TIMERS)) res.status <= ST_FULL;
              else if (tmr_dup) res.status <= ST_DUP;
              else begin
                t_event[t_used[TW-1:0]]  <= cur.event_id;
                t_period[t_used[TW-1:0]] <= cur.period_ms;
                t_last[t_used[TW-1:0]]   <= cur.now_ms + cur.offset_ms -
                    ((cur.offset_ms == 32'd0) ? 32'd0 : cur.period_ms);
                t_active[t_used[TW-1:0]] <= 1'b1;
                t_once[t_used[TW-1:0]]   <= cur.oneshot;
                t_used <= t_used + 1'b1;
              end
            end
            res_valid <= 1'b1;
          end else if (res_ready) begin
            res_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (TCW'(t_idx) >= t_used) begin
            state <= S_DRAIN;
          end else begin
            t_elapsed <= cur.now_ms - t_last[t_idx];
            t_two_per <= {t_period[t_idx], 1'b0};
            t_per_r   <= t_period[t_idx];
            t_due     <= t_active[t_idx];
            state     <= S_TIMER;
          end
        end
        S_TIMER: begin
          if (t_due && t_elapsed >= t_per_r) begin
            if ({1'b0, t_elapsed} >= t_two_per) t_last[t_idx] <= cur.now_ms;
            else t_last[t_idx] <= t_last[t_idx] + t_per_r;
            if (t_once[t_idx]) t_active[t_idx] <= 1'b0;
            if (t_event[t_idx] != 8'd0 && t_event[t_idx] < event_count &&
                q_tail_inc != q_head) begin
              q_event[q_tail] <= t_event[t_idx];
              q_value[q_tail] <= 32'd0;
              q_tail <= q_tail_inc;
            end
          end
          if (t_idx == TW'(TIMERS - 1)) state <= S_DRAIN;
          else begin
            t_idx <= t_idx + 1'b1;
            state <= S_SCAN;
          end
        end
        S_DRAIN: begin
          // Go on to S_DRAIN_WAIT so the registered read of the head is current
          if (q_head == q_tail) begin
            res        <= '{ST_EMPTY, 8'd0, 32'd0, 8'd0, 1'b1};
            res_valid  <= 1'b1;
            state      <= S_OUT;
            cur.action <= ACT_POST;
          end else begin
            state <= S_DRAIN_WAIT;
          end
        end
        S_DRAIN_WAIT: begin
          if (!res_valid) begin
            res <= '{ST_OK, rd_event, rd_value, mask_calc,
                     ((q_head == QW'(QUEUE_DEPTH - 1) ? '0 : q_head + 1'b1) == q_tail)};
            res_valid <= 1'b1;
            q_head    <= (q_head == QW'(QUEUE_DEPTH - 1)) ? '0 : q_head + 1'b1;
          end else if (res_ready) begin
            res_valid <= 1'b0;
            state     <= (q_head == q_tail) ? S_IDLE : S_DRAIN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
